// ===== hdl/mkmd_pkg.sv =====
// Shared types and constants for the multi-key majority debouncer.
// Holds the transfer payload structs, the per-key entry layout and the register map.
// No dependencies.
package mkmd_pkg;

    localparam int KEY_IDX_W       = 3;
    localparam int CNT_W           = 16;
    localparam int KEY_COUNT_DEF   = 8;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [CNT_W-1:0] VOTE_LIMIT_RESET = 16'd16;

    // Register index (word address bit of the APB port)
    localparam logic REG_VOTE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        KEY_OFF  = 2'd0,
        KEY_ON   = 2'd1,
        KEY_VOTE = 2'd2
    } key_status_t;

    typedef struct packed {
        key_status_t      status;
        logic             prev_value;
        logic [CNT_W-1:0] ones_count;
        logic [CNT_W-1:0] zeros_count;
    } key_entry_t;

    localparam key_entry_t ENTRY_RESET = '{
        status:      KEY_VOTE,
        prev_value:  1'b0,
        ones_count:  '0,
        zeros_count: '0
    };

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_index;
        logic                 pin_level;
    } in_item_t;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_echo;
        logic [1:0]           key_state;
        logic                 stable_value;
        logic                 vote_started;
        logic                 vote_done;
    } out_item_t;

endpackage

// ===== hdl/multi_key_majority_debouncer_core.sv =====
// Top level of the multi-key majority debouncer.
// Depends on mkmd_pkg, mkmd_key_ram and mkmd_vote_logic.
//
// Usage:
//   s_ channel: one pin sample per transfer (key_index, pin_level).
//   m_ channel: one result per sample (key_echo, key_state, stable_value,
//               vote_started, vote_done), in input order.
//   APB port:   register 0 at byte address 0 holds vote_limit (16 bits,
//               reset 16). Write it only while no samples are in flight.
// An accepted sample is registered in the read stage, then in the output
//   register, before its result shows on m_. Throughput: one sample per
//   cycle while m_ready is high, back to back, also for repeated samples of
//   the same key; the state memory (one read and one write per cycle) sets that rate.
// Reset (aresetn low, synchronous): every key returns to voting with
//   cleared counters; cleared valid bits mark keys whose memory entry is stale.
// Stall: while m_ready is low the result is held in the output register,
//   one more sample waits in the read stage, and s_ready drops after that.
module multi_key_majority_debouncer_core
    import mkmd_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int EXT_W  = (ADDR_W > KEY_IDX_W) ? ADDR_W : KEY_IDX_W;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] vote_limit_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_limit_reg <= VOTE_LIMIT_RESET;
        end else if (cfg_write && paddr[2] == REG_VOTE_LIMIT) begin
            vote_limit_reg <= pwdata[CNT_W-1:0];
        end
    end

    // read back; word address bit selects the register
    assign prdata = (paddr[2] == REG_VOTE_LIMIT)
                    ? {{(APB_DATA_W-CNT_W){1'b0}}, vote_limit_reg} : '0;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    logic [EXT_W-1:0]  in_idx_ext;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;
    logic              in_xfer;

    assign in_idx_ext = EXT_W'(s_data.key_index);
    assign in_addr    = in_idx_ext[ADDR_W-1:0];
    assign in_range   = (int'(s_data.key_index) < KEY_COUNT);

    // ---------------------------------------------------------------
    // Read stage: memory read in flight, item held until it can advance
    // ---------------------------------------------------------------
    logic              s1_valid_reg, s1_valid_next;
    in_item_t          s1_item_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_range_reg;
    logic              byp_hit_reg, byp_hit_next;
    key_entry_t        byp_data_reg;
    logic              s1_advance;

    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg;

    key_entry_t        ram_rd_data;
    key_entry_t        cur_entry;
    key_entry_t        new_entry;
    out_item_t         result;
    logic              wr_en;

    logic [KEY_COUNT-1:0] vld_reg;

    // advance when the output register is free or is being drained
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign in_xfer    = s_valid && s_ready;
    assign wr_en      = s1_advance && s1_range_reg;

    // A write to the same key at the edge the new read is issued is not
    // seen by that read: flag it and forward the written entry instead.
    assign byp_hit_next  = in_xfer ? (wr_en && (s1_addr_reg == in_addr)) : byp_hit_reg;
    assign s1_valid_next = in_xfer ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            byp_hit_reg  <= byp_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_item_reg  <= s_data;
            s1_addr_reg  <= in_addr;
            s1_range_reg <= in_range;
        end
        if (wr_en) begin
            byp_data_reg <= new_entry;
        end
    end

    // valid bits: an entry never written reads as the reset entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    mkmd_key_ram #(
        .DEPTH  (KEY_COUNT),
        .ADDR_W (ADDR_W)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (new_entry),
        .rd_en   (in_xfer && in_range),
        .rd_addr (in_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        if (byp_hit_reg) begin
            cur_entry = byp_data_reg;
        end else if (s1_range_reg && vld_reg[s1_addr_reg]) begin
            cur_entry = ram_rd_data;
        end else begin
            cur_entry = ENTRY_RESET;
        end
    end

    mkmd_vote_logic u_vote_logic (
        .cur_entry  (cur_entry),
        .item       (s1_item_reg),
        .in_range   (s1_range_reg),
        .vote_limit (vote_limit_reg),
        .new_entry  (new_entry),
        .result     (result)
    );

    // ---------------------------------------------------------------
    // Output register: hold the result until the m_ transfer completes
    // ---------------------------------------------------------------
    assign m_valid_next = s1_advance ? 1'b1 : ((m_valid_reg && m_ready) ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/mkmd_key_ram.sv =====
// Per-key state memory: one write port, one read port with registered read data.
// Depends on mkmd_pkg for the entry layout.
module mkmd_key_ram
    import mkmd_pkg::*;
#(
    parameter int DEPTH  = KEY_COUNT_DEF,
    parameter int ADDR_W = 3
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  key_entry_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output key_entry_t        rd_data
);

    key_entry_t mem [DEPTH];
    key_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mkmd_vote_logic.sv =====
// Vote update for one key sample: next entry and the result item.
// Depends on mkmd_pkg for entry and payload types.
module mkmd_vote_logic
    import mkmd_pkg::*;
(
    input  key_entry_t       cur_entry,
    input  in_item_t         item,
    input  logic             in_range,
    input  logic [CNT_W-1:0] vote_limit,
    output key_entry_t       new_entry,
    output out_item_t        result
);

    logic [CNT_W-1:0] ones_inc;
    logic [CNT_W-1:0] zeros_inc;
    logic             started;
    logic             done;

    assign ones_inc  = (cur_entry.ones_count == '1) ? cur_entry.ones_count
                                                    : cur_entry.ones_count + 1'b1;
    assign zeros_inc = (cur_entry.zeros_count == '1) ? cur_entry.zeros_count
                                                     : cur_entry.zeros_count + 1'b1;

    always_comb begin
        new_entry = cur_entry;
        started   = 1'b0;
        done      = 1'b0;
        case (cur_entry.status)
            KEY_OFF, KEY_ON: begin
                // settled: a differing sample opens a vote, seeded with this sample
                if (item.pin_level != cur_entry.status[0]) begin
                    new_entry.status      = KEY_VOTE;
                    new_entry.prev_value  = cur_entry.status[0];
                    new_entry.ones_count  = {{(CNT_W-1){1'b0}}, item.pin_level};
                    new_entry.zeros_count = {{(CNT_W-1){1'b0}}, ~item.pin_level};
                    started               = 1'b1;
                end
            end
            KEY_VOTE: begin
                if (item.pin_level) begin
                    new_entry.ones_count = ones_inc;
                end else begin
                    new_entry.zeros_count = zeros_inc;
                end
                if (new_entry.ones_count >= vote_limit ||
                    new_entry.zeros_count >= vote_limit) begin
                    // tie settles to off
                    new_entry.status = (new_entry.ones_count > new_entry.zeros_count)
                                       ? KEY_ON : KEY_OFF;
                    done             = 1'b1;
                end
            end
            default: begin
                new_entry = cur_entry;
            end
        endcase
    end

    always_comb begin
        result.key_echo = item.key_index;
        if (in_range) begin
            result.key_state    = new_entry.status;
            result.stable_value = (new_entry.status == KEY_OFF || new_entry.status == KEY_ON)
                                  ? new_entry.status[0] : new_entry.prev_value;
            result.vote_started = started;
            result.vote_done    = done;
        end else begin
            result.key_state    = '0;
            result.stable_value = 1'b0;
            result.vote_started = 1'b0;
            result.vote_done    = 1'b0;
        end
    end

endmodule

// ===== tb/sv/tb_multi_key_majority_debouncer_core.sv =====
// Self-checking testbench for multi_key_majority_debouncer_core: directed table, then random
// key sample runs under random valid/ready pacing, checked against an in-bench vote predictor.
// Depends on mkmd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_multi_key_majority_debouncer_core;
    import mkmd_pkg::*;

    localparam int          BANK_KEYS   = KEY_COUNT_DEF;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned PRINT_CAP   = 30;
    localparam int          DIR_ROWS    = 24;
    localparam int          PHASES      = 7;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    multi_key_majority_debouncer_core #(
        .KEY_COUNT (KEY_COUNT_DEF)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns clock
    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Vote predictor: its own copy of the per-key state and the limit
    // ------------------------------------------------------------------
    key_status_t      key_st    [BANK_KEYS];
    logic             key_prev  [BANK_KEYS];
    logic [CNT_W-1:0] key_ones  [BANK_KEYS];
    logic [CNT_W-1:0] key_zeros [BANK_KEYS];
    logic [CNT_W-1:0] vote_limit_q;

    out_item_t   due_results [$];   // results the core still owes, oldest first
    int unsigned mismatches    = 0;
    int unsigned results_taken = 0;
    int unsigned cycle_count   = 0;
    bit          long_hold_done = 1'b0;

    function automatic void clear_keys();
        for (int k = 0; k < BANK_KEYS; k++) begin
            key_st[k]    = KEY_VOTE;
            key_prev[k]  = 1'b0;
            key_ones[k]  = '0;
            key_zeros[k] = '0;
        end
        vote_limit_q = VOTE_LIMIT_RESET;
    endfunction

    // Apply one pin sample to the key bank and return the result it causes.
    function automatic out_item_t debounce_sample(in_item_t smp);
        out_item_t   r;
        int unsigned k;
        r          = '0;
        r.key_echo = smp.key_index;
        k          = smp.key_index;
        if (k < BANK_KEYS) begin
            case (key_st[k])
                KEY_OFF, KEY_ON: begin
                    // a settled key that sees the other level opens a vote, seeded by this sample
                    if (smp.pin_level != (key_st[k] == KEY_ON)) begin
                        key_prev[k]    = (key_st[k] == KEY_ON);
                        key_st[k]      = KEY_VOTE;
                        key_ones[k]    = {{(CNT_W-1){1'b0}}, smp.pin_level};
                        key_zeros[k]   = {{(CNT_W-1){1'b0}}, ~smp.pin_level};
                        r.vote_started = 1'b1;
                    end
                end
                KEY_VOTE: begin
                    if (smp.pin_level) begin
                        if (key_ones[k] != '1) key_ones[k] = key_ones[k] + 1'b1;
                    end else begin
                        if (key_zeros[k] != '1) key_zeros[k] = key_zeros[k] + 1'b1;
                    end
                    // close on either counter; a tie settles off
                    if (key_ones[k] >= vote_limit_q || key_zeros[k] >= vote_limit_q) begin
                        key_st[k]   = (key_ones[k] > key_zeros[k]) ? KEY_ON : KEY_OFF;
                        r.vote_done = 1'b1;
                    end
                end
                default: ;  // an unknown status stays as it is
            endcase
            r.key_state    = key_st[k];
            r.stable_value = (key_st[k] == KEY_OFF || key_st[k] == KEY_ON) ?
                             (key_st[k] == KEY_ON) : key_prev[k];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting: one line each, capped, always counted
    // ------------------------------------------------------------------
    task automatic report(string msg);
        if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int got, int want, out_item_t ref_item);
        if (got != want)
            report($sformatf("key %0d %s got %0d want %0d", ref_item.key_echo, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Result monitor: compare every transfer with the oldest expectation
    // ------------------------------------------------------------------
    out_item_t want_r;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result %h", m_data));
            end else begin
                want_r = due_results.pop_front();
                check_field("key_echo",     m_data.key_echo,     want_r.key_echo,     want_r);
                check_field("key_state",    m_data.key_state,    want_r.key_state,    want_r);
                check_field("stable_value", m_data.stable_value, want_r.stable_value, want_r);
                check_field("vote_started", m_data.vote_started, want_r.vote_started, want_r);
                check_field("vote_done",    m_data.vote_done,    want_r.vote_done,    want_r);
            end
        end
    end

    // Watchdog: end a hung run as a failure
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready pattern in random modes, plus one long hold-off
    // while the sender keeps offering, so the core fills and drops s_ready
    // ------------------------------------------------------------------
    initial begin : receiver
        int unsigned mode      = 0;
        int unsigned mode_left = 0;
        int unsigned hold_left = 0;
        int unsigned tick      = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && results_taken >= 400 && s_valid) begin
                long_hold_done = 1'b1;
                hold_left      = 120;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;                       // no stalls at all
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= (tick % 4 == 0);            // ready when tick is a multiple of four
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    // Offer one sample and hold it until the transfer; return its prediction.
    task automatic offer_sample(input in_item_t smp, output out_item_t predicted);
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!s_ready);
        predicted = debounce_sample(smp);
    endtask

    // Pace the sender: bursts of random length, random gaps between them.
    task automatic pace();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Drop valid and wait until every owed result has arrived, then settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write of vote_limit: setup phase, then access phase.
    task automatic write_vote_limit(input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_VOTE_LIMIT, 2'b00};
        pwdata  <= {{(APB_DATA_W-CNT_W){1'b0}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vote_limit_q = value;
    endtask

    // ------------------------------------------------------------------
    // Directed table: optional limit write before the row, then the sample;
    // typed rows carry the result read straight off the vote rules
    // ------------------------------------------------------------------
    typedef struct {
        bit               set_lim;
        logic [CNT_W-1:0] lim;
        logic [2:0]       key;
        logic             lvl;
        bit               typed;
        key_status_t      st;
        logic             stable;
        logic             started;
        logic             done;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // after reset every key is voting with empty counters, limit 16
        '{1'b0, 16'd0,     3'd0, 1'b1, 1'b1, KEY_VOTE, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0,     3'd7, 1'b0, 1'b1, KEY_VOTE, 1'b0, 1'b0, 1'b0},
        // limit 1: close, hold, reopen, close
        '{1'b1, 16'd1,     3'd0, 1'b1, 1'b1, KEY_ON,   1'b1, 1'b0, 1'b1},
        '{1'b0, 16'd0,     3'd0, 1'b1, 1'b1, KEY_ON,   1'b1, 1'b0, 1'b0},
        '{1'b0, 16'd0,     3'd0, 1'b0, 1'b1, KEY_VOTE, 1'b1, 1'b1, 1'b0},
        '{1'b0, 16'd0,     3'd0, 1'b0, 1'b1, KEY_OFF,  1'b0, 1'b0, 1'b1},
        // tie at close settles off
        '{1'b0, 16'd0,     3'd7, 1'b1, 1'b1, KEY_OFF,  1'b0, 1'b0, 1'b1},
        // zero limit: the seeding sample never closes, the next one does
        '{1'b1, 16'd0,     3'd0, 1'b1, 1'b1, KEY_VOTE, 1'b0, 1'b1, 1'b0},
        '{1'b0, 16'd0,     3'd0, 1'b1, 1'b1, KEY_ON,   1'b1, 1'b0, 1'b1},
        '{1'b0, 16'd0,     3'd0, 1'b0, 1'b1, KEY_VOTE, 1'b1, 1'b1, 1'b0},
        '{1'b0, 16'd0,     3'd0, 1'b1, 1'b1, KEY_OFF,  1'b0, 1'b0, 1'b1},
        // top limit, then lower it in the middle of the vote
        '{1'b1, 16'hFFFF,  3'd3, 1'b1, 1'b1, KEY_VOTE, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0,     3'd3, 1'b0, 1'b1, KEY_VOTE, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'd2,     3'd3, 1'b1, 1'b1, KEY_ON,   1'b1, 1'b0, 1'b1},
        '{1'b0, 16'd0,     3'd5, 1'b1, 1'b1, KEY_VOTE, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0,     3'd5, 1'b1, 1'b1, KEY_ON,   1'b1, 1'b0, 1'b1},
        '{1'b0, 16'd0,     3'd6, 1'b0, 1'b1, KEY_VOTE, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0,     3'd6, 1'b0, 1'b1, KEY_OFF,  1'b0, 1'b0, 1'b1},
        '{1'b0, 16'd0,     3'd6, 1'b1, 1'b1, KEY_VOTE, 1'b0, 1'b1, 1'b0},
        '{1'b0, 16'd0,     3'd6, 1'b1, 1'b1, KEY_ON,   1'b1, 1'b0, 1'b1},
        // remaining keys, left to the predictor
        '{1'b0, 16'd0,     3'd1, 1'b0, 1'b0, KEY_OFF,  1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0,     3'd2, 1'b1, 1'b0, KEY_OFF,  1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0,     3'd4, 1'b1, 1'b0, KEY_OFF,  1'b0, 1'b0, 1'b0},
        '{1'b0, 16'd0,     3'd4, 1'b0, 1'b0, KEY_OFF,  1'b0, 1'b0, 1'b0}
    };

    // Random phases: limit to write and samples to offer under it
    logic [CNT_W-1:0] phase_lim   [PHASES] = '{16'd16, 16'd1, 16'd0, 16'hFFFF,
                                               16'd4, 16'd0, 16'd2};
    int unsigned      phase_items [PHASES] = '{215, 215, 215, 100, 215, 215, 215};

    // Random sample source: mostly runs on one key with a steady level and
    // a little bounce, the rest single samples on any key
    logic [2:0]  run_key   = '0;
    logic        run_level = 1'b0;
    int unsigned run_left  = 0;

    function automatic in_item_t next_sample(int unsigned span);
        in_item_t smp;
        smp = '0;
        if (run_left == 0 && $urandom_range(0, 3) == 0) begin
            smp.key_index = 3'($urandom_range(0, BANK_KEYS - 1));
            smp.pin_level = 1'($urandom_range(0, 1));
        end else begin
            if (run_left == 0) begin
                run_key   = 3'($urandom_range(0, BANK_KEYS - 1));
                run_level = 1'($urandom_range(0, 1));
                run_left  = $urandom_range(1, span);
            end
            run_left--;
            smp.key_index = run_key;
            smp.pin_level = ($urandom_range(0, 9) == 0) ? ~run_level : run_level;
        end
        return smp;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        in_item_t    smp;
        out_item_t   predicted;
        out_item_t   typed_res;
        int unsigned span;

        clear_keys();
        // hold reset, then release it once
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_lim) begin
                drain();
                write_vote_limit(dir_rows[i].lim);
            end
            smp.key_index = dir_rows[i].key;
            smp.pin_level = dir_rows[i].lvl;
            offer_sample(smp, predicted);
            if (dir_rows[i].typed) begin
                typed_res.key_echo     = dir_rows[i].key;
                typed_res.key_state    = dir_rows[i].st;
                typed_res.stable_value = dir_rows[i].stable;
                typed_res.vote_started = dir_rows[i].started;
                typed_res.vote_done    = dir_rows[i].done;
                due_results.push_back(typed_res);
            end else begin
                due_results.push_back(predicted);
            end
            pace();
        end

        // random part: each phase starts idle with a new limit; key state
        // carries over, so votes in flight see the limit change
        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p == 5) write_vote_limit(CNT_W'($urandom_range(2, 9)));
            else        write_vote_limit(phase_lim[p]);
            span     = ((vote_limit_q > 40) ? 40 : vote_limit_q) + 3;
            run_left = 0;
            for (int n = 0; n < phase_items[p]; n++) begin
                smp = next_sample(span);
                offer_sample(smp, predicted);
                due_results.push_back(predicted);
                pace();
            end
        end

        // wait out the last results, then idle to catch strays
        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
